>>> rtl/core/pbre_pkg.sv
// Shared constants, types and the queue beat format of the PackBits row encoder.
`default_nettype none
package pbre_pkg;
    localparam int unsigned MAX_ROW_DEF    = 4096;
    localparam int unsigned MAX_PACKET_DEF = 128;
    localparam int unsigned CFG_W          = 13;
    localparam int unsigned LEN_W          = 14;
    localparam int unsigned CHUNK_W        = 64;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned TDATA_W        = 88;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = 2;
    localparam int unsigned RES_W          = 5;
    localparam logic [RES_W-1:0]   MAX_RESULTS = 5'd18;
    localparam logic [COUNT_W-1:0] CHUNK_FULL  = 4'd8;

    // One beat between the front and the back: a compressed byte, or the end of a step.
    typedef struct packed {
        logic       step_end;
        logic       row_last;
        logic       first;
        logic       last;
        logic [7:0] data;
    } beat_t;
endpackage
`default_nettype wire

>>> rtl/core/pbre_fifo.sv
// Short beat queue between the packet front and the chunk back.
`default_nettype none
module pbre_fifo
    import pbre_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  beat_t      push_beat,
    output logic       full,
    output logic       head_valid,
    output beat_t      head_beat,
    input  wire logic  pop
);
    beat_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_beat  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/pbre_front.sv
// Packet front: takes input bytes, decides runs and literals, streams packet bytes.
`default_nettype none
module pbre_front
    import pbre_pkg::*;
#(
    parameter int unsigned MAX_ROW    = MAX_ROW_DEF,
    parameter int unsigned MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic [CFG_W-1:0] row_width,
    output logic                  q_push,
    output beat_t                 q_beat,
    input  wire logic             q_full
);
    localparam int unsigned POS_W = $clog2(MAX_ROW + 1);
    localparam int unsigned CMP_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
    localparam int unsigned LC_W  = $clog2(MAX_PACKET + 1);
    localparam int unsigned AW    = $clog2(MAX_PACKET);

    typedef enum logic [1:0] {M_IDLE, M_FIRST, M_RUN, M_LIT} mode_t;
    typedef enum logic [2:0] {S_IN, S_WORK, S_LIT, S_PAIR_H, S_PAIR_B, S_LHDR, S_LBODY} state_t;

    function automatic logic [7:0] run_header(input logic [7:0] n);
        return 8'd1 - n;
    endfunction

    state_t            state_reg;
    mode_t             mode_reg;
    logic [7:0]        run_byte_reg;
    logic [LC_W-1:0]   run_count_reg;
    logic [LC_W-1:0]   lit_count_reg;
    logic [7:0]        look_reg [2];
    logic [1:0]        look_n_reg;
    logic [POS_W-1:0]  row_pos_reg;
    logic              row_last_reg;
    logic [7:0]        wl_reg [3];
    logic [1:0]        wl_n_reg;
    logic [1:0]        wl_i_reg;
    logic [7:0]        q_reg [3];
    logic [1:0]        q_n_reg;
    logic              lit_last_reg;
    logic [7:0]        pair_hdr_reg;
    logic [7:0]        pair_byte_reg;
    logic [AW-1:0]     idx_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        lit_mem [MAX_PACKET];

    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  width_eff;
    logic [CMP_W-1:0]  pos_ext;
    logic              step_last;
    logic [7:0]        cur_b;
    logic              item_last;
    logic              work_done;
    logic              it_stop;
    logic              it_consume;
    logic [LC_W-1:0]   lit_inc;
    logic [7:0]        qs [3];
    logic [1:0]        qs_n;
    logic [7:0]        tmp [3];
    logic [1:0]        tmp_n;
    logic [2:0]        src;
    logic [2:0]        total;
    logic              body_last;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              want_push;
    logic [LC_W-1:0]   run_inc;

    assign s_tready = (state_reg == S_IN);

    always_comb begin
        width_ext = CMP_W'(row_width);
        if (width_ext == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_ROW)) begin
            width_eff = CMP_W'(MAX_ROW);
        end else begin
            width_eff = width_ext;
        end
        pos_ext   = CMP_W'(row_pos_reg) + CMP_W'(1);
        step_last = (pos_ext >= width_eff);
    end

    assign cur_b     = wl_reg[wl_i_reg];
    assign work_done = (wl_i_reg == wl_n_reg);
    assign item_last = row_last_reg && (wl_i_reg == 2'(wl_n_reg - 2'd1));
    assign run_inc   = run_count_reg + 1'b1;
    assign body_last = (idx_reg == AW'(lit_count_reg - 1'b1));

    // One pass of the literal scan over the pending bytes.
    always_comb begin
        it_stop    = 1'b0;
        it_consume = 1'b0;
        if (q_n_reg == 2'd1) begin
            it_stop = lit_last_reg;
        end else if (q_reg[0] == q_reg[1]) begin
            if (q_n_reg == 2'd2) begin
                it_consume = lit_last_reg;
            end else if (q_reg[0] == q_reg[2]) begin
                it_stop = 1'b1;
            end else begin
                it_consume = 1'b1;
            end
        end else begin
            it_consume = 1'b1;
        end
        lit_inc = lit_count_reg + 1'b1;
        if (it_consume && (lit_inc >= LC_W'(MAX_PACKET))) begin
            it_stop = 1'b1;
        end
        if (it_consume) begin
            qs[0] = q_reg[1];
            qs[1] = q_reg[2];
            qs[2] = q_reg[2];
            qs_n  = q_n_reg - 2'd1;
        end else begin
            qs[0] = q_reg[0];
            qs[1] = q_reg[1];
            qs[2] = q_reg[2];
            qs_n  = q_n_reg;
        end
        // Pending bytes go back to the head of the work list, then the rest of it.
        src = '0;
        for (int k = 0; k < 3; k++) begin
            src = 3'(wl_i_reg) + 3'(k) - 3'(qs_n);
            if (3'(k) < 3'(qs_n)) begin
                tmp[k] = qs[k];
            end else if (src < 3'(wl_n_reg)) begin
                tmp[k] = wl_reg[src[1:0]];
            end else begin
                tmp[k] = 8'd0;
            end
        end
        total = 3'(qs_n) + 3'(wl_n_reg) - 3'(wl_i_reg);
        tmp_n = (total > 3'd3) ? 2'd3 : total[1:0];
    end

    always_comb begin
        want_push = 1'b0;
        q_beat    = '0;
        unique case (state_reg)
            S_WORK: begin
                want_push         = work_done;
                q_beat.step_end   = 1'b1;
                q_beat.row_last   = row_last_reg;
            end
            S_PAIR_H: begin
                want_push    = 1'b1;
                q_beat.first = 1'b1;
                q_beat.data  = pair_hdr_reg;
            end
            S_PAIR_B: begin
                want_push   = 1'b1;
                q_beat.last = 1'b1;
                q_beat.data = pair_byte_reg;
            end
            S_LHDR: begin
                want_push    = 1'b1;
                q_beat.first = 1'b1;
                q_beat.data  = 8'(lit_count_reg - 1'b1);
            end
            S_LBODY: begin
                want_push   = 1'b1;
                q_beat.last = body_last;
                q_beat.data = rd_data_reg;
            end
            default: begin
                want_push = 1'b0;
            end
        endcase
        q_push = want_push && !q_full;
    end

    always_comb begin
        if (state_reg == S_LBODY) begin
            rd_addr = (q_push && !body_last) ? AW'(idx_reg + 1'b1) : idx_reg;
        end else if (state_reg == S_LHDR) begin
            rd_addr = '0;
        end else begin
            rd_addr = idx_reg;
        end
        mem_we    = 1'b0;
        mem_waddr = AW'(lit_count_reg);
        mem_wdata = q_reg[0];
        if (state_reg == S_WORK && !work_done && mode_reg == M_FIRST && cur_b != run_byte_reg) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = run_byte_reg;
        end else if (state_reg == S_LIT && it_consume) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lit_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= lit_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IN;
            mode_reg      <= M_IDLE;
            run_count_reg <= '0;
            lit_count_reg <= '0;
            look_n_reg    <= '0;
            row_pos_reg   <= '0;
            row_last_reg  <= 1'b0;
            wl_n_reg      <= '0;
            wl_i_reg      <= '0;
            q_n_reg       <= '0;
            idx_reg       <= '0;
        end else begin
            unique case (state_reg)
                S_IN: begin
                    if (s_tvalid) begin
                        wl_reg[0]    <= s_tdata;
                        wl_n_reg     <= 2'd1;
                        wl_i_reg     <= 2'd0;
                        row_last_reg <= step_last;
                        row_pos_reg  <= step_last ? '0 : POS_W'(pos_ext);
                        state_reg    <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (work_done) begin
                        if (q_push) begin
                            if (row_last_reg) begin
                                mode_reg   <= M_IDLE;
                                look_n_reg <= '0;
                            end
                            state_reg <= S_IN;
                        end
                    end else begin
                        unique case (mode_reg)
                            M_IDLE: begin
                                wl_i_reg <= wl_i_reg + 1'b1;
                                if (item_last) begin
                                    pair_hdr_reg  <= 8'd0;
                                    pair_byte_reg <= cur_b;
                                    state_reg     <= S_PAIR_H;
                                end else begin
                                    mode_reg     <= M_FIRST;
                                    run_byte_reg <= cur_b;
                                end
                            end
                            M_FIRST: begin
                                wl_i_reg <= wl_i_reg + 1'b1;
                                if (cur_b == run_byte_reg) begin
                                    run_count_reg <= LC_W'(2);
                                    if ((MAX_PACKET <= 2) || item_last) begin
                                        pair_hdr_reg  <= run_header(8'd2);
                                        pair_byte_reg <= run_byte_reg;
                                        mode_reg      <= M_IDLE;
                                        state_reg     <= S_PAIR_H;
                                    end else begin
                                        mode_reg <= M_RUN;
                                    end
                                end else begin
                                    lit_count_reg <= LC_W'(1);
                                    look_n_reg    <= '0;
                                    mode_reg      <= M_LIT;
                                    q_reg[0]      <= cur_b;
                                    q_n_reg       <= 2'd1;
                                    lit_last_reg  <= item_last;
                                    state_reg     <= S_LIT;
                                end
                            end
                            M_RUN: begin
                                pair_byte_reg <= run_byte_reg;
                                if (cur_b == run_byte_reg &&
                                    run_count_reg < LC_W'(MAX_PACKET)) begin
                                    wl_i_reg      <= wl_i_reg + 1'b1;
                                    run_count_reg <= run_inc;
                                    if (run_inc >= LC_W'(MAX_PACKET) || item_last) begin
                                        pair_hdr_reg <= run_header(8'(run_inc));
                                        mode_reg     <= M_IDLE;
                                        state_reg    <= S_PAIR_H;
                                    end
                                end else begin
                                    // The byte that broke the run is handled again in idle.
                                    pair_hdr_reg <= run_header(8'(run_count_reg));
                                    mode_reg     <= M_IDLE;
                                    state_reg    <= S_PAIR_H;
                                end
                            end
                            M_LIT: begin
                                wl_i_reg     <= wl_i_reg + 1'b1;
                                q_reg[0]     <= (look_n_reg != 2'd0) ? look_reg[0] : cur_b;
                                q_reg[1]     <= (look_n_reg == 2'd2) ? look_reg[1] : cur_b;
                                q_reg[2]     <= cur_b;
                                q_n_reg      <= look_n_reg + 2'd1;
                                lit_last_reg <= item_last;
                                state_reg    <= S_LIT;
                            end
                            default: begin
                                mode_reg <= M_IDLE;
                            end
                        endcase
                    end
                end
                S_LIT: begin
                    if (it_consume) begin
                        lit_count_reg <= lit_inc;
                        q_reg[0]      <= qs[0];
                        q_reg[1]      <= qs[1];
                        q_reg[2]      <= qs[2];
                        q_n_reg       <= qs_n;
                    end
                    if (it_stop) begin
                        mode_reg   <= M_IDLE;
                        look_n_reg <= '0;
                        wl_reg[0]  <= tmp[0];
                        wl_reg[1]  <= tmp[1];
                        wl_reg[2]  <= tmp[2];
                        wl_n_reg   <= tmp_n;
                        wl_i_reg   <= '0;
                        state_reg  <= S_LHDR;
                    end else if (!it_consume) begin
                        look_reg[0] <= q_reg[0];
                        look_reg[1] <= q_reg[1];
                        look_n_reg  <= q_n_reg;
                        state_reg   <= S_WORK;
                    end
                end
                S_PAIR_H: begin
                    if (q_push) begin
                        state_reg <= S_PAIR_B;
                    end
                end
                S_PAIR_B: begin
                    if (q_push) begin
                        state_reg <= S_WORK;
                    end
                end
                S_LHDR: begin
                    if (q_push) begin
                        idx_reg   <= '0;
                        state_reg <= S_LBODY;
                    end
                end
                S_LBODY: begin
                    if (q_push) begin
                        if (body_last) begin
                            state_reg <= S_WORK;
                        end else begin
                            idx_reg <= AW'(idx_reg + 1'b1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IN;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/pbre_back.sv
// Chunk back: packs queued packet bytes into chunks and drives the output register.
`default_nettype none
module pbre_back
    import pbre_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  beat_t                   q_beat,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);
    logic                pend_valid_reg;
    logic [CHUNK_W-1:0]  pend_data_reg;
    logic [COUNT_W-1:0]  pend_cnt_reg;
    logic                pend_pkt_end_reg;
    logic [RES_W-1:0]    res_n_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                out_valid_reg;
    logic [CHUNK_W-1:0]  out_data_reg;
    logic [COUNT_W-1:0]  out_cnt_reg;
    logic                out_pkt_end_reg;
    logic                out_row_end_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic out_free;
    logic start_new;
    logic need_push;

    assign out_free  = !out_valid_reg || m_tready;
    assign start_new = (res_n_reg < MAX_RESULTS) &&
                       (q_beat.first || !pend_valid_reg || pend_cnt_reg == CHUNK_FULL);
    assign need_push = pend_valid_reg && (q_beat.step_end || start_new);
    assign q_pop     = q_valid && (!need_push || out_free);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pkt_end_reg;
    assign m_tlast  = out_row_end_reg;
    assign m_tdata  = TDATA_W'({out_len_reg, out_cnt_reg, out_data_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            res_n_reg      <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (q_pop && need_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (need_push) begin
                    out_data_reg    <= pend_data_reg;
                    out_cnt_reg     <= pend_cnt_reg;
                    out_pkt_end_reg <= pend_pkt_end_reg;
                    out_row_end_reg <= q_beat.step_end && q_beat.row_last;
                    out_len_reg     <= (q_beat.step_end && q_beat.row_last) ? len_reg : '0;
                end
                if (q_beat.step_end) begin
                    pend_valid_reg <= 1'b0;
                    res_n_reg      <= '0;
                    if (q_beat.row_last) begin
                        len_reg <= '0;
                    end
                end else begin
                    len_reg <= len_reg + 1'b1;
                    if (start_new) begin
                        pend_valid_reg   <= 1'b1;
                        pend_data_reg    <= CHUNK_W'(q_beat.data);
                        pend_cnt_reg     <= COUNT_W'(1);
                        pend_pkt_end_reg <= q_beat.last;
                        res_n_reg        <= res_n_reg + 1'b1;
                    end else if (pend_cnt_reg != CHUNK_FULL) begin
                        pend_data_reg[{pend_cnt_reg[2:0], 3'b000} +: 8] <= q_beat.data;
                        pend_cnt_reg     <= pend_cnt_reg + 1'b1;
                        pend_pkt_end_reg <= q_beat.last;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/packbits_row_encoder_core.sv
// Top level of the PackBits row encoder: configuration register, front, queue and back.
//
// Channel   Direction  Beat contents
// cfg_*     in         cfg_data: row width in bytes (13 bits)
// s_axis    in         s_tdata: one raw sample byte
// m_axis    out        m_tdata: chunk bytes, count, row length; m_tuser: packet end;
//                      m_tlast: row end
//
// Each input beat is accepted, then each pending byte it moves goes through the packet
// decision logic, and a step-end beat closes the step; every settled packet is streamed
// by the front one byte per cycle while the queue is not full (two for a run, count plus
// one for a literal).
// The byte-wide front-to-back queue and the single literal store read port set that rate.
// Reset is synchronous and active low; it leaves the row width at one and no packet open.
// The back packs queued bytes into chunks independently, so a stalled output only stops
// the front once the queue has filled.
`default_nettype none
module packbits_row_encoder_core
    import pbre_pkg::*;
#(
    parameter int unsigned MAX_ROW    = MAX_ROW_DEF,
    parameter int unsigned MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data,    // row_width
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,     // sample_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,     // chunk_data, chunk_count, row_length, zero pad
    output logic                    m_tuser,     // packet_end
    output logic                    m_tlast      // row_end
);
    logic [CFG_W-1:0] row_width_reg;
    logic             q_push;
    beat_t            q_in_beat;
    logic             q_full;
    logic             q_valid;
    beat_t            q_head;
    logic             q_pop;

    // The register is always writable; the user must write it only between rows, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= CFG_W'(1);
        end else if (cfg_valid) begin
            row_width_reg <= cfg_data;
        end
    end

    // The front decides packets and streams their bytes, header first.
    pbre_front #(
        .MAX_ROW    (MAX_ROW),
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .row_width (row_width_reg),
        .q_push    (q_push),
        .q_beat    (q_in_beat),
        .q_full    (q_full)
    );

    pbre_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_beat  (q_in_beat),
        .full       (q_full),
        .head_valid (q_valid),
        .head_beat  (q_head),
        .pop        (q_pop)
    );

    // The back gathers bytes into chunks of up to eight and counts the row length.
    pbre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_beat   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire
